FILE: design/dit_pkg.sv
package dit_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  typedef struct packed {
    logic [47:0] addr;
    logic [31:0] latest_ms;
    logic [31:0] created_ms;
    logic [31:0] count;
    logic [7:0]  signal;
    logic [1:0]  kind;
    logic [31:0] summary;
    logic        named;
    logic [31:0] name_tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic               req_type;
    logic [47:0]        device_addr;
    logic [1:0]         addr_class;
    logic signed [7:0]  signal_dbm;
    logic [31:0]        now_ms;
    logic [31:0]        ad_summary;
    logic               carries_name;
    logic [31:0]        name_tag;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  slot_index;
    logic        was_new;
    logic        was_evicted;
    logic [31:0] times_seen;
    logic [31:0] created_ms;
    logic        stored_has_name;
    logic [31:0] stored_name_tag;
    logic [5:0]  entries_used;
  } out_word_t;

  typedef struct packed {
    logic             init;
    logic             en;
    logic [IDX_W-1:0] idx;
    logic             slot_valid;
  } scan_ctl_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    entry_t           hit_entry;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] min_idx;
  } scan_res_t;

  function automatic logic [4:0] to_slot_index(input logic [IDX_W-1:0] idx);
    logic [63:0] wide;
    wide = 64'(idx);
    return wide[4:0];
  endfunction

  function automatic logic [5:0] to_entries_used(input logic [CNT_W-1:0] cnt);
    logic [63:0] wide;
    wide = 64'(cnt);
    return wide[5:0];
  endfunction

endpackage

FILE: design/dit_ram.sv
module dit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/dit_scan.sv
module dit_scan import dit_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  scan_ctl_t   ctl,
  input  logic [47:0] key,
  input  entry_t      rd_entry,
  output scan_res_t   res
);

  logic             hit_found_r;
  logic             free_found_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic [IDX_W-1:0] free_idx_r;
  logic [IDX_W-1:0] min_idx_r;
  logic [31:0]      min_last_r;
  entry_t           hit_entry_r;
  logic             hit_now;
  logic             free_now;
  logic             take_min;

  assign hit_now  = ctl.slot_valid && (rd_entry.addr == key) && !hit_found_r;
  assign free_now = !ctl.slot_valid && !free_found_r;
  assign take_min = (ctl.idx == '0) || (rd_entry.latest_ms < min_last_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (ctl.init) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (ctl.en) begin
      if (hit_now) begin
        hit_found_r <= 1'b1;
      end
      if (free_now) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (hit_now) begin
        hit_idx_r   <= ctl.idx;
        hit_entry_r <= rd_entry;
      end
      if (free_now) begin
        free_idx_r <= ctl.idx;
      end
      if (take_min) begin
        min_last_r <= rd_entry.latest_ms;
        min_idx_r  <= ctl.idx;
      end
    end
  end

  assign res.hit        = hit_found_r;
  assign res.hit_idx    = hit_idx_r;
  assign res.hit_entry  = hit_entry_r;
  assign res.free_found = free_found_r;
  assign res.free_idx   = free_idx_r;
  assign res.min_idx    = min_idx_r;

endmodule

FILE: design/device_inventory_table.sv
// Device inventory table. An observation word is taken when start is high and busy is low;
// it scans every slot through one table memory port, one slot per cycle, then writes the
// updated entry. A record word keeps busy high through the scan, flush and write states, so
// no new word is taken before that entry is written; a clear word clears the valid bits and
// leaves busy low. Each word gives exactly one result word, shown for one cycle with
// out_strobe on the cycle after the work ends; the receiver cannot hold it off and must
// take it then. No clearing pass follows reset: slot valid bits reset at once.
module device_inventory_table import dit_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_word_t  in_word,
  output logic      busy,
  output logic      out_strobe,
  output out_word_t out_word
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_WRITE = 4'b1000
  } state_t;

  state_t             state_r;
  logic [IDX_W-1:0]   issue_idx_r;
  logic               lag_en_r;
  logic [IDX_W-1:0]   lag_idx_r;
  logic [ENTRIES-1:0] valid_r;
  logic [CNT_W-1:0]   used_r;
  in_word_t           in_r;
  out_word_t          out_r;
  logic               out_strobe_r;

  logic             accept;
  scan_ctl_t        ctl;
  scan_res_t        scan;
  entry_t           rd_entry;
  logic [ENTRY_W-1:0] rd_bits;
  entry_t           base;
  entry_t           upd;
  logic [IDX_W-1:0] pick;
  logic             fresh;
  logic             evicted;
  logic [CNT_W-1:0] used_nxt;
  logic             we;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign ctl.init       = accept && (in_word.req_type == REQ_RECORD);
  assign ctl.en         = lag_en_r;
  assign ctl.idx        = lag_idx_r;
  assign ctl.slot_valid = valid_r[lag_idx_r];

  assign rd_entry = entry_t'(rd_bits);
  assign we       = (state_r == ST_WRITE);

  dit_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (pick),
    .wdata (ENTRY_W'(upd)),
    .raddr (issue_idx_r),
    .rdata (rd_bits)
  );

  dit_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .key      (in_r.device_addr),
    .rd_entry (rd_entry),
    .res      (scan)
  );

  always_comb begin
    fresh   = !scan.hit && scan.free_found;
    evicted = !scan.hit && !scan.free_found;
    if (scan.hit) begin
      pick = scan.hit_idx;
    end else if (scan.free_found) begin
      pick = scan.free_idx;
    end else begin
      pick = scan.min_idx;
    end

    if (scan.hit) begin
      base = scan.hit_entry;
    end else begin
      base            = scan.hit_entry;
      base.addr       = in_r.device_addr;
      base.created_ms = in_r.now_ms;
      base.count      = '0;
      base.named      = 1'b0;
      base.name_tag   = '0;
    end

    upd           = base;
    upd.kind      = in_r.addr_class;
    upd.signal    = in_r.signal_dbm;
    upd.summary   = in_r.ad_summary;
    upd.latest_ms = in_r.now_ms;
    if (in_r.carries_name || !base.named) begin
      upd.named    = in_r.carries_name;
      upd.name_tag = in_r.carries_name ? in_r.name_tag : '0;
    end
    if (base.count != COUNT_MAX) begin
      upd.count = base.count + 32'd1;
    end

    used_nxt = used_r + CNT_W'(fresh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      issue_idx_r  <= '0;
      lag_en_r     <= 1'b0;
      valid_r      <= '0;
      used_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      lag_en_r     <= (state_r == ST_SCAN);
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_word.req_type == REQ_CLEAR) begin
              valid_r      <= '0;
              used_r       <= '0;
              out_strobe_r <= 1'b1;
            end else begin
              issue_idx_r <= '0;
              state_r     <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          issue_idx_r <= issue_idx_r + IDX_W'(1);
          if (issue_idx_r == IDX_W'(ENTRIES - 1)) begin
            state_r <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          state_r <= ST_WRITE;
        end
        ST_WRITE: begin
          valid_r[pick] <= 1'b1;
          used_r        <= used_nxt;
          out_strobe_r  <= 1'b1;
          state_r       <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lag_idx_r <= issue_idx_r;
    if (accept) begin
      in_r <= in_word;
      if (in_word.req_type == REQ_CLEAR) begin
        out_r <= '0;
      end
    end
    if (state_r == ST_WRITE) begin
      out_r.slot_index      <= to_slot_index(pick);
      out_r.was_new         <= fresh;
      out_r.was_evicted     <= evicted;
      out_r.times_seen      <= upd.count;
      out_r.created_ms      <= upd.created_ms;
      out_r.stored_has_name <= upd.named;
      out_r.stored_name_tag <= upd.name_tag;
      out_r.entries_used    <= to_entries_used(used_nxt);
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_r;

  a_used_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    used_r == CNT_W'($countones(valid_r)))
    else $error("occupied count differs from valid bits");

  a_evict_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE && evicted) |-> (&valid_r))
    else $error("eviction with a free slot");

  a_write_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |=> out_strobe)
    else $error("update without result word");

  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(state_r) == ST_WRITE) || $past(accept && in_word.req_type))
    else $error("result word without cause");

endmodule

FILE: sim/device_inventory_table_tb.sv
`timescale 1ns / 100ps

module device_inventory_table_tb;
  import dit_pkg::*;

  localparam int POOL_SIZE = 40;

  logic      clk;
  logic      rst_n;
  logic      start;
  in_word_t  in_word;
  logic      busy;
  logic      out_strobe;
  out_word_t out_word;

  // shadow copy of the device table
  logic        known_valid [ENTRIES];
  logic [47:0] known_addr  [ENTRIES];
  logic [31:0] known_last  [ENTRIES];
  logic [31:0] known_first [ENTRIES];
  logic [31:0] known_count [ENTRIES];
  logic        known_named [ENTRIES];
  logic [31:0] known_tag   [ENTRIES];

  out_word_t   predicted_reports[$];
  int unsigned failures;
  logic [31:0] clock_ms;
  logic [47:0] addr_pool [POOL_SIZE];

  device_inventory_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_word    (in_word),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic out_word_t observe_device(in_word_t w);
    int hit;
    int free_idx;
    int pick;
    int used;
    out_word_t r;
    hit = -1;
    free_idx = -1;
    used = 0;
    r = '0;
    if (w.req_type == REQ_CLEAR) begin
      for (int i = 0; i < ENTRIES; i++) known_valid[i] = 1'b0;
      return r;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (known_valid[i] && known_addr[i] == w.device_addr && hit < 0) hit = i;
      if (!known_valid[i] && free_idx < 0) free_idx = i;
    end
    if (hit >= 0) begin
      pick = hit;
    end else if (free_idx >= 0) begin
      pick = free_idx;
      r.was_new = 1'b1;
    end else begin
      // least recently seen, lowest slot on ties
      pick = 0;
      for (int i = 1; i < ENTRIES; i++)
        if (known_last[i] < known_last[pick]) pick = i;
      r.was_evicted = 1'b1;
    end
    if (hit < 0) begin
      known_valid[pick] = 1'b1;
      known_addr[pick]  = w.device_addr;
      known_first[pick] = w.now_ms;
      known_count[pick] = '0;
      known_named[pick] = 1'b0;
      known_tag[pick]   = '0;
    end
    if (w.carries_name || !known_named[pick]) begin
      known_named[pick] = w.carries_name;
      known_tag[pick]   = w.carries_name ? w.name_tag : 32'h0;
    end
    known_last[pick] = w.now_ms;
    if (known_count[pick] != COUNT_MAX) known_count[pick] = known_count[pick] + 32'd1;
    for (int i = 0; i < ENTRIES; i++) used += int'(known_valid[i]);
    r.slot_index      = 5'(pick);
    r.times_seen      = known_count[pick];
    r.created_ms      = known_first[pick];
    r.stored_has_name = known_named[pick];
    r.stored_name_tag = known_tag[pick];
    r.entries_used    = 6'(used);
    return r;
  endfunction

  function automatic string describe(out_word_t w);
    return $sformatf("slot=%0d new=%b evicted=%b seen=%0d first=%h named=%b tag=%h used=%0d",
                     w.slot_index, w.was_new, w.was_evicted, w.times_seen, w.created_ms,
                     w.stored_has_name, w.stored_name_tag, w.entries_used);
  endfunction

  always @(posedge clk) begin
    out_word_t expected;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) known_valid[i] = 1'b0;
      predicted_reports.delete();
    end else begin
      if (out_strobe) begin
        if (predicted_reports.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected report word at %0t: %s", $realtime, describe(out_word));
        end else begin
          expected = predicted_reports.pop_front();
          if (out_word.slot_index !== expected.slot_index ||
              out_word.was_new !== expected.was_new ||
              out_word.was_evicted !== expected.was_evicted ||
              out_word.times_seen !== expected.times_seen ||
              out_word.created_ms !== expected.created_ms ||
              out_word.stored_has_name !== expected.stored_has_name ||
              out_word.stored_name_tag !== expected.stored_name_tag ||
              out_word.entries_used !== expected.entries_used) begin
            failures++;
            if (failures <= 10)
              $display("report mismatch at %0t\n  expected %s\n  got      %s",
                       $realtime, describe(expected), describe(out_word));
          end
        end
      end
      if (start && !busy) predicted_reports.push_back(observe_device(in_word));
    end
  end

  task automatic send_word(in_word_t w);
    @(negedge clk);
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle(int cycles);
    repeat (cycles) @(negedge clk) start <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk) start <= 1'b0;
    while (predicted_reports.size() != 0) @(posedge clk);
  endtask

  function automatic in_word_t obs(logic [47:0] a, logic [1:0] kind, logic [7:0] sig,
                                   logic [31:0] now, logic [31:0] summ, logic named,
                                   logic [31:0] tag);
    in_word_t w;
    w.req_type     = REQ_RECORD;
    w.device_addr  = a;
    w.addr_class   = kind;
    w.signal_dbm   = sig;
    w.now_ms       = now;
    w.ad_summary   = summ;
    w.carries_name = named;
    w.name_tag     = tag;
    return w;
  endfunction

  function automatic in_word_t random_obs(logic [47:0] a, logic [31:0] now);
    return obs(a, 2'($urandom), 8'($urandom), now, $urandom, 1'($urandom), $urandom);
  endfunction

  function automatic in_word_t clear_word();
    in_word_t w;
    w = in_word_t'(156'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    w.req_type = REQ_CLEAR;
    return w;
  endfunction

  function automatic logic [31:0] next_time();
    case ($urandom_range(19))
      0:       clock_ms = $urandom;
      1:       clock_ms = 32'hFFFF_FFFF - $urandom_range(3);
      2:       clock_ms = $urandom_range(3);
      default: clock_ms = clock_ms + $urandom_range(0, 3);
    endcase
    return clock_ms;
  endfunction

  function automatic void fill_pool();
    logic [47:0] base;
    base = 48'({$urandom, $urandom});
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i < 10) addr_pool[i] = base ^ (48'd1 << $urandom_range(47));
      else addr_pool[i] = 48'({$urandom, $urandom});
    end
    addr_pool[10] = '0;
    addr_pool[11] = '1;
  endfunction

  task automatic test_field_extremes();
    send_word(clear_word());
    send_word(obs(48'h0, 2'd0, 8'h80, 32'h0, 32'h0, 1'b0, 32'h0));
    send_word(obs('1, 2'd3, 8'h7F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    send_word(obs(48'h0, 2'd1, 8'h00, 32'h10, 32'hA5A5_5A5A, 1'b0, 32'hDEAD_BEEF));
    send_word(obs(48'hAAAA_AAAA_AAAA, 2'd2, 8'hFF, 32'h8000_0000, 32'h5A5A_A5A5, 1'b1, 32'h0));
    send_word(obs(48'h5555_5555_5555, 2'd1, 8'h01, 32'h7FFF_FFFF, 32'h1, 1'b0, 32'h1));
    send_word(obs('1, 2'd2, 8'h80, 32'h0, 32'h0, 1'b0, 32'h0));
  endtask

  task automatic test_name_keep();
    send_word(obs(48'h0123_4567_89AB, 2'd0, 8'hC4, 32'd100, 32'h11, 1'b1, 32'h1111_0001));
    send_word(obs(48'h0123_4567_89AB, 2'd1, 8'hC0, 32'd101, 32'h12, 1'b0, 32'h2222_0002));
    send_word(obs(48'h0123_4567_89AB, 2'd2, 8'hBC, 32'd102, 32'h13, 1'b1, 32'h3333_0003));
    send_word(obs(48'h0123_4567_89AB, 2'd3, 8'hB8, 32'd103, 32'h14, 1'b0, 32'h0));
    send_word(obs(48'h0123_4567_89AA, 2'd0, 8'hD0, 32'd104, 32'h15, 1'b0, 32'h4444_0004));
    send_word(obs(48'h0123_4567_89AA, 2'd0, 8'hD1, 32'd105, 32'h16, 1'b1, 32'h5555_0005));
  endtask

  task automatic test_clear();
    send_word(obs(48'hFEED_0000_0001, 2'd1, 8'h10, 32'd200, 32'h0, 1'b1, 32'h77));
    send_word(clear_word());
    send_word(obs(48'hFEED_0000_0001, 2'd1, 8'h11, 32'd201, 32'h0, 1'b0, 32'h0));
    send_word(clear_word());
  endtask

  // fill the table with tied and wrapped times, then force evictions
  task automatic test_eviction();
    logic [47:0] seen [ENTRIES];
    logic [31:0] t;
    send_word(clear_word());
    for (int i = 0; i < ENTRIES; i++) begin
      seen[i] = 48'({$urandom, $urandom});
      case ($urandom_range(3))
        0:       t = 32'd7;
        1:       t = 32'hFFFF_FFFF;
        default: t = $urandom;
      endcase
      send_word(random_obs(seen[i], t));
    end
    for (int i = 0; i < 8; i++)
      send_word(random_obs(48'({$urandom, $urandom}), 32'hFFFF_FFF0 + i));
    for (int i = 0; i < 4; i++)
      send_word(random_obs(seen[$urandom_range(ENTRIES - 1)], 32'd3));
  endtask

  task automatic test_random_traffic(int count, int idle_pct);
    int          r;
    logic [47:0] a;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < idle_pct) idle($urandom_range(1, 40));
      r = $urandom_range(99);
      if (r < 2) begin
        send_word(clear_word());
      end else begin
        if (r < 14) begin
          a = 48'({$urandom, $urandom});
          addr_pool[$urandom_range(POOL_SIZE - 1)] = a;
        end else begin
          a = addr_pool[$urandom_range(POOL_SIZE - 1)];
        end
        send_word(random_obs(a, next_time()));
      end
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    start    = 1'b0;
    in_word  = '0;
    failures = 0;
    clock_ms = '0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_field_extremes();
    test_name_keep();
    test_clear();
    test_eviction();
    wait_drained();

    fill_pool();
    test_random_traffic(230, 13);
    wait_drained();
    fill_pool();
    test_random_traffic(230, 61);
    wait_drained();
    fill_pool();
    clock_ms = 32'hFFFF_FF00;
    test_random_traffic(230, 0);

    wait_drained();
    repeat (ENTRIES + 8) @(posedge clk);
    if (predicted_reports.size() != 0) failures++;
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
